@@ sv/ppi_pkg.sv @@
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, widths and constants of the polyphonic pulse interrupter,
// including the note-to-step table.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned NOTE_W   = 7;
    localparam int unsigned STEP_W   = 14;
    localparam int unsigned PHASE_W  = 17;
    localparam int unsigned WIDTH_W  = 8;
    localparam int unsigned MASK_W   = 3;
    localparam int unsigned CFG_W    = 17;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [PHASE_W-1:0] MODULUS_RESET = 17'd100000;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET   = 8'd20;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS = 1'b0,
        CFG_WIDTH   = 1'b1
    } cfg_idx_t;

    // round(220 * 2^((n-57)/12)), rounded half up
    function automatic logic [STEP_W-1:0] note_step(input logic [NOTE_W-1:0] n);
        logic [STEP_W-1:0] s;
        begin
            unique case (n)
                7'd0:   s = 14'd8;
                7'd1:   s = 14'd9;
                7'd2:   s = 14'd9;
                7'd3:   s = 14'd10;
                7'd4:   s = 14'd10;
                7'd5:   s = 14'd11;
                7'd6:   s = 14'd12;
                7'd7:   s = 14'd12;
                7'd8:   s = 14'd13;
                7'd9:   s = 14'd14;
                7'd10:  s = 14'd15;
                7'd11:  s = 14'd15;
                7'd12:  s = 14'd16;
                7'd13:  s = 14'd17;
                7'd14:  s = 14'd18;
                7'd15:  s = 14'd19;
                7'd16:  s = 14'd21;
                7'd17:  s = 14'd22;
                7'd18:  s = 14'd23;
                7'd19:  s = 14'd24;
                7'd20:  s = 14'd26;
                7'd21:  s = 14'd28;
                7'd22:  s = 14'd29;
                7'd23:  s = 14'd31;
                7'd24:  s = 14'd33;
                7'd25:  s = 14'd35;
                7'd26:  s = 14'd37;
                7'd27:  s = 14'd39;
                7'd28:  s = 14'd41;
                7'd29:  s = 14'd44;
                7'd30:  s = 14'd46;
                7'd31:  s = 14'd49;
                7'd32:  s = 14'd52;
                7'd33:  s = 14'd55;
                7'd34:  s = 14'd58;
                7'd35:  s = 14'd62;
                7'd36:  s = 14'd65;
                7'd37:  s = 14'd69;
                7'd38:  s = 14'd73;
                7'd39:  s = 14'd78;
                7'd40:  s = 14'd82;
                7'd41:  s = 14'd87;
                7'd42:  s = 14'd92;
                7'd43:  s = 14'd98;
                7'd44:  s = 14'd104;
                7'd45:  s = 14'd110;
                7'd46:  s = 14'd117;
                7'd47:  s = 14'd123;
                7'd48:  s = 14'd131;
                7'd49:  s = 14'd139;
                7'd50:  s = 14'd147;
                7'd51:  s = 14'd156;
                7'd52:  s = 14'd165;
                7'd53:  s = 14'd175;
                7'd54:  s = 14'd185;
                7'd55:  s = 14'd196;
                7'd56:  s = 14'd208;
                7'd57:  s = 14'd220;
                7'd58:  s = 14'd233;
                7'd59:  s = 14'd247;
                7'd60:  s = 14'd262;
                7'd61:  s = 14'd277;
                7'd62:  s = 14'd294;
                7'd63:  s = 14'd311;
                7'd64:  s = 14'd330;
                7'd65:  s = 14'd349;
                7'd66:  s = 14'd370;
                7'd67:  s = 14'd392;
                7'd68:  s = 14'd415;
                7'd69:  s = 14'd440;
                7'd70:  s = 14'd466;
                7'd71:  s = 14'd494;
                7'd72:  s = 14'd523;
                7'd73:  s = 14'd554;
                7'd74:  s = 14'd587;
                7'd75:  s = 14'd622;
                7'd76:  s = 14'd659;
                7'd77:  s = 14'd698;
                7'd78:  s = 14'd740;
                7'd79:  s = 14'd784;
                7'd80:  s = 14'd831;
                7'd81:  s = 14'd880;
                7'd82:  s = 14'd932;
                7'd83:  s = 14'd988;
                7'd84:  s = 14'd1047;
                7'd85:  s = 14'd1109;
                7'd86:  s = 14'd1175;
                7'd87:  s = 14'd1245;
                7'd88:  s = 14'd1319;
                7'd89:  s = 14'd1397;
                7'd90:  s = 14'd1480;
                7'd91:  s = 14'd1568;
                7'd92:  s = 14'd1661;
                7'd93:  s = 14'd1760;
                7'd94:  s = 14'd1865;
                7'd95:  s = 14'd1976;
                7'd96:  s = 14'd2093;
                7'd97:  s = 14'd2217;
                7'd98:  s = 14'd2349;
                7'd99:  s = 14'd2489;
                7'd100: s = 14'd2637;
                7'd101: s = 14'd2794;
                7'd102: s = 14'd2960;
                7'd103: s = 14'd3136;
                7'd104: s = 14'd3322;
                7'd105: s = 14'd3520;
                7'd106: s = 14'd3729;
                7'd107: s = 14'd3951;
                7'd108: s = 14'd4186;
                7'd109: s = 14'd4435;
                7'd110: s = 14'd4699;
                7'd111: s = 14'd4978;
                7'd112: s = 14'd5274;
                7'd113: s = 14'd5588;
                7'd114: s = 14'd5920;
                7'd115: s = 14'd6272;
                7'd116: s = 14'd6645;
                7'd117: s = 14'd7040;
                7'd118: s = 14'd7459;
                7'd119: s = 14'd7902;
                7'd120: s = 14'd8372;
                7'd121: s = 14'd8870;
                7'd122: s = 14'd9397;
                7'd123: s = 14'd9956;
                7'd124: s = 14'd10548;
                7'd125: s = 14'd11175;
                7'd126: s = 14'd11840;
                default: s = 14'd12544;
            endcase
            return s;
        end
    endfunction

endpackage

@@ sv/polyphonic_pulse_interrupter.sv @@
// ----------------------------------------------------------------------------
// polyphonic_pulse_interrupter
// Multi-voice pulse generator: note events claim and free voices, ticks step
// each voice's phase accumulator and fire fixed-width pulses on wrap.
// ----------------------------------------------------------------------------
// Use:
//   Item channel (item_valid / item_stall, op, note): one beat per tick or
//   note event. Note events and the unused op code give no result.
//   Result channel (result_valid / result_stall, pulse_out, voices_active):
//   one beat per tick, in order.
//   Config port (cfg_we, cfg_index, cfg_data): write phase modulus or pulse
//   width while the block is idle; takes effect at once.
// Timing:
//   An accepted beat is held in the input register and, once it may advance,
//   is applied to the voice registers at the edge that also loads the result
//   register, which drives result_valid.
//   One beat per cycle while no tick stalls; the voice update is a single
//   pass of adds, compares and a first-free search across all voices.
// Reset:
//   All voices off, phases and counters zero, modulus 100000, width 20.
// Stall:
//   While result_stall holds a waiting result, a tick in the input register
//   waits and item_stall rises; note events still pass through.
// ----------------------------------------------------------------------------
module polyphonic_pulse_interrupter #(
    parameter int unsigned VOICES = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [ppi_pkg::OP_W-1:0]            op,
    input  logic [ppi_pkg::NOTE_W-1:0]          note,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                pulse_out,
    output logic [ppi_pkg::MASK_W-1:0]          voices_active,
    input  logic                                cfg_we,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppi_pkg::CFG_W-1:0]           cfg_data
);

    logic [ppi_pkg::PHASE_W-1:0] modulus_reg;
    logic [ppi_pkg::WIDTH_W-1:0] width_reg;

    logic                        s1_valid_reg;
    logic [ppi_pkg::OP_W-1:0]    s1_op_reg;
    logic [ppi_pkg::NOTE_W-1:0]  s1_note_reg;
    logic                        s1_adv;
    logic                        s1_tick;
    logic                        item_take;

    logic [VOICES-1:0]           voice_on_reg;
    logic [VOICES-1:0]           voice_on_next;
    logic [ppi_pkg::NOTE_W-1:0]  voice_note_reg  [VOICES];
    logic [ppi_pkg::NOTE_W-1:0]  voice_note_next [VOICES];
    logic [ppi_pkg::STEP_W-1:0]  voice_step_reg  [VOICES];
    logic [ppi_pkg::STEP_W-1:0]  voice_step_next [VOICES];
    logic [ppi_pkg::PHASE_W-1:0] voice_phase_reg [VOICES];
    logic [ppi_pkg::PHASE_W-1:0] voice_phase_next[VOICES];
    logic [ppi_pkg::WIDTH_W-1:0] voice_left_reg  [VOICES];
    logic [ppi_pkg::WIDTH_W-1:0] voice_left_next [VOICES];

    logic                        res_valid_reg;
    logic                        res_pulse_reg;
    logic                        res_pulse_next;
    logic [ppi_pkg::MASK_W-1:0]  res_mask_reg;
    logic [ppi_pkg::MASK_W-1:0]  res_mask_next;

    // ---- config ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= ppi_pkg::MODULUS_RESET;
            width_reg   <= ppi_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (ppi_pkg::cfg_idx_t'(cfg_index))
                ppi_pkg::CFG_MODULUS: modulus_reg <= cfg_data;
                ppi_pkg::CFG_WIDTH:   width_reg   <= cfg_data[ppi_pkg::WIDTH_W-1:0];
                default:              ;
            endcase
        end
    end

    // ---- input register ----
    assign s1_tick    = (ppi_pkg::op_t'(s1_op_reg) == ppi_pkg::OP_TICK);
    assign s1_adv     = s1_valid_reg && (!s1_tick || !res_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_adv;
    assign item_take  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_op_reg   <= op;
            s1_note_reg <= note;
        end
    end

    // ---- voice update ----
    always_comb
    begin
        logic                         found;
        logic [ppi_pkg::PHASE_W:0]    sum;
        logic [ppi_pkg::WIDTH_W-1:0]  left;

        found          = 1'b0;
        sum            = '0;
        left           = '0;
        voice_on_next  = voice_on_reg;
        res_pulse_next = 1'b0;
        res_mask_next  = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            voice_note_next[v]  = voice_note_reg[v];
            voice_step_next[v]  = voice_step_reg[v];
            voice_phase_next[v] = voice_phase_reg[v];
            voice_left_next[v]  = voice_left_reg[v];
        end

        if (s1_adv)
        begin
            unique case (ppi_pkg::op_t'(s1_op_reg))
                ppi_pkg::OP_TICK:
                begin
                    for (int v = 0; v < VOICES; v++)
                    begin
                        left = voice_left_reg[v];
                        if (voice_on_reg[v])
                        begin
                            sum = {1'b0, voice_phase_reg[v]}
                                + {{(ppi_pkg::PHASE_W + 1 - ppi_pkg::STEP_W){1'b0}},
                                   voice_step_reg[v]};
                            if (sum >= {1'b0, modulus_reg})
                            begin
                                sum  = sum - {1'b0, modulus_reg};
                                left = width_reg;
                            end
                            voice_phase_next[v] = sum[ppi_pkg::PHASE_W-1:0];
                        end
                        if (left != '0)
                        begin
                            res_pulse_next = 1'b1;
                            left           = left - 1'b1;
                        end
                        voice_left_next[v] = left;
                        if (v < ppi_pkg::MASK_W)
                        begin
                            res_mask_next[v] = voice_on_reg[v];
                        end
                    end
                end
                ppi_pkg::OP_NOTE_ON:
                begin
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (!found && !voice_on_reg[v])
                        begin
                            found              = 1'b1;
                            voice_on_next[v]   = 1'b1;
                            voice_note_next[v] = s1_note_reg;
                            voice_step_next[v] = ppi_pkg::note_step(s1_note_reg);
                        end
                    end
                end
                ppi_pkg::OP_NOTE_OFF:
                begin
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (voice_note_reg[v] == s1_note_reg)
                        begin
                            voice_on_next[v] = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_on_reg <= '0;
            for (int v = 0; v < VOICES; v++)
            begin
                voice_note_reg[v]  <= '0;
                voice_step_reg[v]  <= '0;
                voice_phase_reg[v] <= '0;
                voice_left_reg[v]  <= '0;
            end
        end
        else
        begin
            voice_on_reg <= voice_on_next;
            for (int v = 0; v < VOICES; v++)
            begin
                voice_note_reg[v]  <= voice_note_next[v];
                voice_step_reg[v]  <= voice_step_next[v];
                voice_phase_reg[v] <= voice_phase_next[v];
                voice_left_reg[v]  <= voice_left_next[v];
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_tick)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_tick)
        begin
            res_pulse_reg <= res_pulse_next;
            res_mask_reg  <= res_mask_next;
        end
    end

    assign result_valid  = res_valid_reg;
    assign pulse_out     = res_pulse_reg;
    assign voices_active = res_mask_reg;

    // ---- assertions ----
    a_stall_only_when_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && s1_tick && res_valid_reg && result_stall))
        else $error("item stalled without a waiting tick");

    a_tick_gives_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_tick) |=> result_valid)
        else $error("processed tick gave no result beat");

    a_tick_keeps_voices: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_tick) |=> $stable(voice_on_reg))
        else $error("tick changed voice allocation");

    a_note_on_claims_one: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_adv && (ppi_pkg::op_t'(s1_op_reg) == ppi_pkg::OP_NOTE_ON) && !(&voice_on_reg))
        |=> ($countones(voice_on_reg) == $countones($past(voice_on_reg)) + 1))
        else $error("note-on did not claim exactly one voice");

endmodule

@@ test/ppi_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppi_checker
// Watches the item, result and register ports of the pulse interrupter,
// keeps its own copy of the voice state, works out the level and voice mask
// that each tick must give and compares every result beat with the oldest
// one still due.
// ----------------------------------------------------------------------------
module ppi_checker #(
    parameter int unsigned VOICES = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_stall,
    input  logic [ppi_pkg::OP_W-1:0]        op,
    input  logic [ppi_pkg::NOTE_W-1:0]      note,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic                            pulse_out,
    input  logic [ppi_pkg::MASK_W-1:0]      voices_active,
    input  logic                            cfg_we,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppi_pkg::CFG_W-1:0]       cfg_data,
    output int                              mismatches,
    output int                              pending
);

    typedef struct packed {
        logic                       level;
        logic [ppi_pkg::MASK_W-1:0] mask;
    } tick_level_t;

    tick_level_t                 due_levels[$];

    logic [ppi_pkg::STEP_W-1:0]  step_lut[128];
    logic [ppi_pkg::PHASE_W-1:0] modulus;
    logic [ppi_pkg::WIDTH_W-1:0] width;
    logic                        v_on[VOICES];
    logic [ppi_pkg::NOTE_W-1:0]  v_note[VOICES];
    logic [ppi_pkg::STEP_W-1:0]  v_step[VOICES];
    logic [ppi_pkg::PHASE_W-1:0] v_phase[VOICES];
    logic [ppi_pkg::WIDTH_W-1:0] v_left[VOICES];

    // equal-tempered steps, A3 = 220, halves rounded up
    initial
    begin
        int hz;
        for (int n = 0; n < 128; n++)
        begin
            hz = int'($floor(220.0 * 2.0 ** ((n - 57) / 12.0) + 0.5));
            step_lut[n] = hz[ppi_pkg::STEP_W-1:0];
        end
    end

    task automatic flag(input string what, input int want, input int got);
        mismatches++;
        $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic advance_voices(output tick_level_t r);
        logic [ppi_pkg::PHASE_W:0] sum;
        r = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (v_on[v])
            begin
                sum = {1'b0, v_phase[v]} + (ppi_pkg::PHASE_W+1)'(v_step[v]);
                if (sum >= {1'b0, modulus})
                begin
                    sum = sum - {1'b0, modulus};
                    v_left[v] = width;
                end
                v_phase[v] = sum[ppi_pkg::PHASE_W-1:0];
            end
        end
        for (int v = 0; v < VOICES; v++)
        begin
            if (v_left[v] != '0)
            begin
                r.level = 1'b1;
                v_left[v] = v_left[v] - 1'b1;
            end
            if (v_on[v] && v < ppi_pkg::MASK_W)
                r.mask[v] = 1'b1;
        end
    endtask

    task automatic claim_voice(input logic [ppi_pkg::NOTE_W-1:0] n);
        bit done;
        done = 0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (!done && !v_on[v])
            begin
                v_on[v]   = 1'b1;
                v_note[v] = n;
                v_step[v] = step_lut[n];
                done = 1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_level_t want;
        if (!rst_n)
        begin
            modulus = ppi_pkg::MODULUS_RESET;
            width   = ppi_pkg::WIDTH_RESET;
            for (int v = 0; v < VOICES; v++)
            begin
                v_on[v]    = 1'b0;
                v_note[v]  = '0;
                v_step[v]  = '0;
                v_phase[v] = '0;
                v_left[v]  = '0;
            end
            due_levels.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ppi_pkg::CFG_MODULUS: modulus = cfg_data[ppi_pkg::PHASE_W-1:0];
                    ppi_pkg::CFG_WIDTH:   width   = cfg_data[ppi_pkg::WIDTH_W-1:0];
                    default:              ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (due_levels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: beat with nothing due (pulse_out %0d, voices_active %0d)",
                             $time, pulse_out, voices_active);
                end
                else
                begin
                    want = due_levels.pop_front();
                    if (pulse_out !== want.level)
                        flag("pulse_out", want.level, pulse_out);
                    if (voices_active !== want.mask)
                        flag("voices_active", want.mask, voices_active);
                end
            end
            if (item_valid && !item_stall)
            begin
                case (op)
                    ppi_pkg::OP_TICK:
                    begin
                        advance_voices(want);
                        due_levels.push_back(want);
                    end
                    ppi_pkg::OP_NOTE_ON:
                        claim_voice(note);
                    ppi_pkg::OP_NOTE_OFF:
                        for (int v = 0; v < VOICES; v++)
                            if (v_note[v] == note)
                                v_on[v] = 1'b0;
                    default:
                        ;
                endcase
            end
            pending = due_levels.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives note events, ticks and register writes into the pulse interrupter
// in random bursts against a stalling receiver, with one long hold-off, and
// gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [ppi_pkg::OP_W-1:0] OP_SPARE    = 2'd3;
    localparam int                       CYCLE_LIMIT = 200000;
    localparam int                       HOLD_AFTER  = 700;
    localparam int                       HOLD_CYCLES = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_stall;
    logic [ppi_pkg::OP_W-1:0]      op;
    logic [ppi_pkg::NOTE_W-1:0]    note;
    logic                          result_valid;
    logic                          result_stall;
    logic                          pulse_out;
    logic [ppi_pkg::MASK_W-1:0]    voices_active;
    logic                          cfg_we;
    logic [ppi_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ppi_pkg::CFG_W-1:0]     cfg_data;

    int                            mismatches;
    int                            pending;
    int                            beats_sent;
    logic [ppi_pkg::NOTE_W-1:0]    held_notes[4];
    int                            held_wr;

    polyphonic_pulse_interrupter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .note          (note),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .pulse_out     (pulse_out),
        .voices_active (voices_active),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ppi_checker ppi_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .note          (note),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .pulse_out     (pulse_out),
        .voices_active (voices_active),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stall patterns in turn; one long hold-off
    initial
    begin : receiver
        int  mode;
        int  k;
        bit  held_off;
        result_stall = 1'b0;
        held_off = 0;
        forever
        begin
            if (!held_off && beats_sent >= HOLD_AFTER)
            begin
                held_off = 1;
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            for (k = 0; k < 64; k++)
            begin
                @(negedge clk);
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 9) < 7);
                    default: result_stall <= ((k % 8) < 3);
                endcase
            end
        end
    end

    task automatic put_beat(input logic [ppi_pkg::OP_W-1:0] o,
                            input logic [ppi_pkg::NOTE_W-1:0] n);
        @(negedge clk);
        item_valid <= 1'b1;
        op         <= o;
        note       <= n;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // drain every due tick, then let note events clear the pipe
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input ppi_pkg::cfg_idx_t idx,
                                  input logic [ppi_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_voicing(input logic [ppi_pkg::CFG_W-1:0] wrap,
                               input logic [ppi_pkg::WIDTH_W-1:0] w);
        settle();
        write_register(ppi_pkg::CFG_MODULUS, wrap);
        write_register(ppi_pkg::CFG_WIDTH, (ppi_pkg::CFG_W)'(w));
    endtask

    // note-offs mostly hit a recently played note so voices keep turning over
    task automatic random_run(input int count);
        int                         burst;
        int                         pick;
        int                         i;
        logic [ppi_pkg::OP_W-1:0]   o;
        logic [ppi_pkg::NOTE_W-1:0] n;
        burst = $urandom_range(1, 40);
        for (i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 8));
                burst = $urandom_range(1, 40);
            end
            burst--;
            pick = $urandom_range(0, 99);
            n = (ppi_pkg::NOTE_W)'($urandom_range(0, 127));
            if (pick < 58)
                o = ppi_pkg::OP_TICK;
            else if (pick < 77)
            begin
                o = ppi_pkg::OP_NOTE_ON;
                held_notes[held_wr] = n;
                held_wr = (held_wr + 1) % 4;
            end
            else if (pick < 95)
            begin
                o = ppi_pkg::OP_NOTE_OFF;
                if ($urandom_range(0, 4) != 0)
                    n = held_notes[$urandom_range(0, 3)];
            end
            else
                o = OP_SPARE;
            put_beat(o, n);
        end
    endtask

    initial
    begin : stimulus
        rst_n      = 1'b0;
        item_valid = 1'b0;
        op         = ppi_pkg::OP_TICK;
        note       = '0;
        cfg_we     = 1'b0;
        cfg_index  = ppi_pkg::CFG_MODULUS;
        cfg_data   = '0;
        beats_sent = 0;
        held_wr    = 0;
        for (int j = 0; j < 4; j++)
            held_notes[j] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty voices, unused voices holding note 0, full voices,
        // unused op code, note-off of a note nobody holds
        put_beat(ppi_pkg::OP_TICK, 7'd127);
        put_beat(ppi_pkg::OP_NOTE_OFF, 7'd0);
        put_beat(ppi_pkg::OP_TICK, 7'd0);
        put_beat(ppi_pkg::OP_NOTE_ON, 7'd0);
        put_beat(ppi_pkg::OP_NOTE_ON, 7'd127);
        put_beat(ppi_pkg::OP_NOTE_ON, 7'd57);
        put_beat(ppi_pkg::OP_NOTE_ON, 7'd64);
        put_beat(ppi_pkg::OP_TICK, 7'd85);
        put_beat(ppi_pkg::OP_TICK, 7'd42);
        put_beat(ppi_pkg::OP_NOTE_OFF, 7'd127);
        put_beat(ppi_pkg::OP_TICK, 7'd0);
        put_beat(ppi_pkg::OP_NOTE_ON, 7'd21);
        put_beat(ppi_pkg::OP_TICK, 7'd0);
        put_beat(OP_SPARE, 7'd127);
        put_beat(ppi_pkg::OP_NOTE_OFF, 7'd99);
        put_beat(ppi_pkg::OP_TICK, 7'd0);
        put_beat(ppi_pkg::OP_NOTE_OFF, 7'd0);
        put_beat(ppi_pkg::OP_NOTE_ON, 7'd127);
        put_beat(ppi_pkg::OP_TICK, 7'd0);
        put_beat(ppi_pkg::OP_NOTE_OFF, 7'd57);
        put_beat(ppi_pkg::OP_NOTE_OFF, 7'd21);
        put_beat(ppi_pkg::OP_TICK, 7'd0);

        set_voicing(17'd1000, 8'd1);
        random_run(300);
        set_voicing(17'd100000, 8'd255);
        random_run(300);
        // zero wrap fires on every tick and lets phases roll over 17 bits;
        // zero width starts no new pulse
        set_voicing(17'd0, 8'd0);
        random_run(300);
        // phases left far above the new wrap are reduced once per tick
        set_voicing(17'd1500, 8'd255);
        random_run(300);
        set_voicing(17'd131071, 8'd128);
        random_run(300);
        set_voicing((ppi_pkg::CFG_W)'($urandom_range(1000, 5000)),
                    (ppi_pkg::WIDTH_W)'($urandom_range(1, 255)));
        random_run(300);

        settle();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
